// ----- rtl/c2tc_pkg.sv -----
// ----------------------------------------------------------------------------
// c2tc_pkg : shared constants and tables for calendar_to_tick_count
// Field widths, tick scaling, reciprocal constants and the month tables.
// ----------------------------------------------------------------------------
package c2tc_pkg;

   // field widths
   localparam int YEAR_W   = 14;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int HOUR_W   = 5;
   localparam int MINUTE_W = 6;
   localparam int SECOND_W = 6;
   localparam int MSEC_W   = 10;
   localparam int TICK_W   = 62;

   // tick scaling, 100 ns ticks by default
   localparam int TICKS_PER_MS = 10000;
   localparam int TICKS_W      = $clog2(TICKS_PER_MS + 1);

   // internal widths
   localparam int DAYS_W   = 22;   // days up to year 9999
   localparam int DOFF_W   = 9;    // day offset inside a year
   localparam int TOD_W    = 27;   // milliseconds in a day
   localparam int MS_W     = 49;   // milliseconds since the epoch
   localparam int MS_LO_W  = 25;
   localparam int MS_HI_W  = MS_W - MS_LO_W;

   // divide by 100 through a reciprocal, exact for 14-bit values
   localparam int DIV100_MUL   = 5243;
   localparam int DIV100_SHIFT = 19;
   localparam int DIV100_MUL_W = 13;
   localparam int Q100_W       = 8;
   localparam int Q400_W       = 6;

   localparam int DAYS_PER_YEAR = 365;
   localparam int MS_PER_DAY    = 86400000;
   localparam int MS_PER_HOUR   = 3600000;
   localparam int MS_PER_MINUTE = 60000;
   localparam int MS_PER_SECOND = 1000;

   localparam int YEAR_MAX   = 9999;
   localparam int MONTH_MAX  = 12;
   localparam int HOUR_MAX   = 23;
   localparam int MINUTE_MAX = 59;
   localparam int SECOND_MAX = 59;
   localparam int MSEC_MAX   = 999;
   localparam int LEAP_DAY   = 29;

   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
   localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
   localparam logic [MONTH_W-1:0] MONTH_MAY = 4'd5;
   localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
   localparam logic [MONTH_W-1:0] MONTH_JUL = 4'd7;
   localparam logic [MONTH_W-1:0] MONTH_AUG = 4'd8;
   localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
   localparam logic [MONTH_W-1:0] MONTH_OCT = 4'd10;
   localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   // days in the year before the first of the month
   function automatic logic [DOFF_W-1:0] days_before_month(input logic [MONTH_W-1:0] month);
      logic [DOFF_W-1:0] result;
      unique case (month)
         MONTH_JAN: result = 9'd0;
         MONTH_FEB: result = 9'd31;
         MONTH_MAR: result = 9'd59;
         MONTH_APR: result = 9'd90;
         MONTH_MAY: result = 9'd120;
         MONTH_JUN: result = 9'd151;
         MONTH_JUL: result = 9'd181;
         MONTH_AUG: result = 9'd212;
         MONTH_SEP: result = 9'd243;
         MONTH_OCT: result = 9'd273;
         MONTH_NOV: result = 9'd304;
         MONTH_DEC: result = 9'd334;
         default:   result = 9'd0;
      endcase
      return result;
   endfunction

   // month length in a common year
   function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] month);
      logic [DAY_W-1:0] result;
      unique case (month)
         MONTH_FEB: result = 5'd28;
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: result = 5'd30;
         MONTH_JAN, MONTH_MAR, MONTH_MAY, MONTH_JUL,
         MONTH_AUG, MONTH_OCT, MONTH_DEC: result = 5'd31;
         default: result = 5'd0;
      endcase
      return result;
   endfunction

endpackage

// ----- rtl/c2tc_req_if.sv -----
// ----------------------------------------------------------------------------
// c2tc_req_if : timestamp request channel
// Valid/ready channel that carries one broken-down calendar timestamp a beat.
// ----------------------------------------------------------------------------
interface c2tc_req_if;
   logic                               valid;
   logic                               ready;
   logic [c2tc_pkg::YEAR_W-1:0]        year;
   logic [c2tc_pkg::MONTH_W-1:0]       month;
   logic [c2tc_pkg::DAY_W-1:0]         day;
   logic [c2tc_pkg::HOUR_W-1:0]        hour;
   logic [c2tc_pkg::MINUTE_W-1:0]      minute;
   logic [c2tc_pkg::SECOND_W-1:0]      second;
   logic [c2tc_pkg::MSEC_W-1:0]        millisecond;

   modport source (
      output valid, year, month, day, hour, minute, second, millisecond,
      input  ready
   );
   modport sink (
      input  valid, year, month, day, hour, minute, second, millisecond,
      output ready
   );
endinterface

// ----- rtl/c2tc_rsp_if.sv -----
// ----------------------------------------------------------------------------
// c2tc_rsp_if : tick count response channel
// Valid/ready channel that carries one tick count and its valid flag a beat.
// ----------------------------------------------------------------------------
interface c2tc_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [c2tc_pkg::TICK_W-1:0]        tick_count;
   logic                               input_valid;

   modport source (
      output valid, tick_count, input_valid,
      input  ready
   );
   modport sink (
      input  valid, tick_count, input_valid,
      output ready
   );
endinterface

// ----- rtl/calendar_to_tick_count.sv -----
// ----------------------------------------------------------------------------
// calendar_to_tick_count : calendar timestamp to tick count converter
// Converts a proleptic Gregorian date and time of day into ticks since
// 0001-01-01 00:00:00.000, with full range checking of every field.
// ----------------------------------------------------------------------------
// Usage
//   req_bus (sink) takes one timestamp a beat: year, month, day, hour,
//   minute, second, millisecond. rsp_bus (source) gives one beat back for
//   each request: tick_count and input_valid. A request that fails any range
//   check, or names a day past the end of its month, returns input_valid = 0
//   and tick_count = 0.
//   The pipeline has six register stages, the last being the output register
//   (year split, leap/day offset, day sum, day to millisecond multiply, tick
//   scaling in two partial products, final sum). A new request is taken
//   every cycle unless a waiting response is held off, so the throughput is
//   one beat per cycle while the output is not stalled.
//   When rsp_bus.ready is low with a response waiting, the whole pipeline
//   holds and req_bus.ready drops in the same cycle; nothing is lost or
//   repeated. Reset clears all stage valid bits, so the block comes up empty.
// ----------------------------------------------------------------------------
module calendar_to_tick_count (
   input  logic       clock,
   input  logic       reset,
   c2tc_req_if.sink   req_bus,
   c2tc_rsp_if.source rsp_bus
);

   logic advance;

   // stage 1: year split and field range checks
   logic                               s1_valid_ff;
   logic [c2tc_pkg::YEAR_W-1:0]        s1_year_ff;
   logic [c2tc_pkg::YEAR_W-1:0]        s1_y_ff;
   logic [c2tc_pkg::Q100_W-1:0]        s1_q100_year_ff, s1_q100_y_ff;
   logic [c2tc_pkg::Q400_W-1:0]        s1_q400_y_ff;
   logic [c2tc_pkg::MONTH_W-1:0]       s1_month_ff;
   logic [c2tc_pkg::DAY_W-1:0]         s1_day_ff;
   logic [c2tc_pkg::TOD_W-1:0]         s1_tod_ff;
   logic                               s1_ok_ff, s1_day_fits_ff, s1_feb29_ff;

   logic [c2tc_pkg::YEAR_W-1:0]        s1_y_in;
   logic [c2tc_pkg::YEAR_W+c2tc_pkg::DIV100_MUL_W-1:0] s1_prod_year, s1_prod_y;
   logic [c2tc_pkg::YEAR_W+c2tc_pkg::DIV100_MUL_W-3:0] s1_prod_y4;
   logic [c2tc_pkg::TOD_W-1:0]         s1_tod_in;
   logic                               s1_ok_in;

   // stage 2: days for whole years, offset inside the year
   logic                               s2_valid_ff;
   logic [c2tc_pkg::DAYS_W-1:0]        s2_days_year_ff;
   logic [c2tc_pkg::DOFF_W-1:0]        s2_doff_ff;
   logic [c2tc_pkg::TOD_W-1:0]         s2_tod_ff;
   logic                               s2_ok_ff;

   logic                               s2_div4, s2_div100, s2_leap;
   logic [c2tc_pkg::DAYS_W:0]          s2_days_year_in;
   logic [c2tc_pkg::DOFF_W-1:0]        s2_doff_in;
   logic                               s2_ok_in;

   // stage 3: day number
   logic                               s3_valid_ff;
   logic [c2tc_pkg::DAYS_W-1:0]        s3_days_ff;
   logic [c2tc_pkg::TOD_W-1:0]         s3_tod_ff;
   logic                               s3_ok_ff;

   // stage 4: milliseconds since epoch
   logic                               s4_valid_ff;
   logic [c2tc_pkg::MS_W-1:0]          s4_ms_ff;
   logic                               s4_ok_ff;
   logic [c2tc_pkg::MS_W-1:0]          s4_ms_in;

   // stage 5: tick scaling partial products
   logic                               s5_valid_ff;
   logic [c2tc_pkg::MS_LO_W+c2tc_pkg::TICKS_W-1:0] s5_lo_ff;
   logic [c2tc_pkg::MS_HI_W+c2tc_pkg::TICKS_W-1:0] s5_hi_ff;
   logic                               s5_ok_ff;

   // stage 6: output register
   logic                               out_valid_ff;
   logic [c2tc_pkg::TICK_W-1:0]        out_ticks_ff;
   logic                               out_ok_ff;
   logic [c2tc_pkg::TICK_W-1:0]        out_ticks_in;

   // whole pipeline moves unless a response is waiting and held off
   assign advance       = !out_valid_ff || rsp_bus.ready;
   assign req_bus.ready = advance;

   // ---------------- stage 1 ----------------
   always_comb begin
      s1_y_in      = req_bus.year - c2tc_pkg::YEAR_W'(1);
      s1_prod_year = (c2tc_pkg::YEAR_W+c2tc_pkg::DIV100_MUL_W)'(req_bus.year)
                   * (c2tc_pkg::YEAR_W+c2tc_pkg::DIV100_MUL_W)'(c2tc_pkg::DIV100_MUL);
      s1_prod_y    = (c2tc_pkg::YEAR_W+c2tc_pkg::DIV100_MUL_W)'(s1_y_in)
                   * (c2tc_pkg::YEAR_W+c2tc_pkg::DIV100_MUL_W)'(c2tc_pkg::DIV100_MUL);
      // (y/4)/100 gives y/400
      s1_prod_y4   = (c2tc_pkg::YEAR_W+c2tc_pkg::DIV100_MUL_W-2)'(s1_y_in[c2tc_pkg::YEAR_W-1:2])
                   * (c2tc_pkg::YEAR_W+c2tc_pkg::DIV100_MUL_W-2)'(c2tc_pkg::DIV100_MUL);
      s1_tod_in    = c2tc_pkg::TOD_W'(req_bus.hour) * c2tc_pkg::TOD_W'(c2tc_pkg::MS_PER_HOUR)
                   + c2tc_pkg::TOD_W'(req_bus.minute) * c2tc_pkg::TOD_W'(c2tc_pkg::MS_PER_MINUTE)
                   + c2tc_pkg::TOD_W'(req_bus.second) * c2tc_pkg::TOD_W'(c2tc_pkg::MS_PER_SECOND)
                   + c2tc_pkg::TOD_W'(req_bus.millisecond);
      s1_ok_in     = (req_bus.year != '0)
                  && (req_bus.year <= c2tc_pkg::YEAR_W'(c2tc_pkg::YEAR_MAX))
                  && (req_bus.month != '0)
                  && (req_bus.month <= c2tc_pkg::MONTH_W'(c2tc_pkg::MONTH_MAX))
                  && (req_bus.day != '0)
                  && (req_bus.hour <= c2tc_pkg::HOUR_W'(c2tc_pkg::HOUR_MAX))
                  && (req_bus.minute <= c2tc_pkg::MINUTE_W'(c2tc_pkg::MINUTE_MAX))
                  && (req_bus.second <= c2tc_pkg::SECOND_W'(c2tc_pkg::SECOND_MAX))
                  && (req_bus.millisecond <= c2tc_pkg::MSEC_W'(c2tc_pkg::MSEC_MAX));
   end

   // ---------------- stage 2 ----------------
   always_comb begin
      s2_div4   = (s1_year_ff[1:0] == 2'd0);
      s2_div100 = s2_div4 && ((c2tc_pkg::YEAR_W+1)'(s1_q100_year_ff) * (c2tc_pkg::YEAR_W+1)'(100)
                              == (c2tc_pkg::YEAR_W+1)'(s1_year_ff));
      // a multiple of 100 is a multiple of 400 exactly when it is one of 16
      s2_leap   = s2_div4 && (!s2_div100 || (s1_year_ff[3:0] == 4'd0));
      s2_days_year_in = (c2tc_pkg::DAYS_W+1)'(s1_y_ff) * (c2tc_pkg::DAYS_W+1)'(c2tc_pkg::DAYS_PER_YEAR)
                      + (c2tc_pkg::DAYS_W+1)'(s1_y_ff[c2tc_pkg::YEAR_W-1:2])
                      - (c2tc_pkg::DAYS_W+1)'(s1_q100_y_ff)
                      + (c2tc_pkg::DAYS_W+1)'(s1_q400_y_ff);
      s2_doff_in = c2tc_pkg::days_before_month(s1_month_ff)
                 + c2tc_pkg::DOFF_W'(s2_leap && (s1_month_ff > c2tc_pkg::MONTH_FEB))
                 + c2tc_pkg::DOFF_W'(s1_day_ff) - c2tc_pkg::DOFF_W'(1);
      s2_ok_in   = s1_ok_ff && (s1_day_fits_ff || (s1_feb29_ff && s2_leap));
   end

   // ---------------- stage 4 ----------------
   assign s4_ms_in = c2tc_pkg::MS_W'(s3_days_ff) * c2tc_pkg::MS_W'(c2tc_pkg::MS_PER_DAY)
                   + c2tc_pkg::MS_W'(s3_tod_ff);

   // ---------------- stage 6 ----------------
   always_comb begin
      out_ticks_in = c2tc_pkg::TICK_W'(s5_lo_ff)
                   + (c2tc_pkg::TICK_W'(s5_hi_ff) << c2tc_pkg::MS_LO_W);
      if (!s5_ok_ff) begin
         out_ticks_in = '0;
      end
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= req_bus.valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         s5_valid_ff  <= s4_valid_ff;
         out_valid_ff <= s5_valid_ff;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_year_ff      <= req_bus.year;
         s1_y_ff         <= s1_y_in;
         s1_q100_year_ff <= s1_prod_year[c2tc_pkg::DIV100_SHIFT +: c2tc_pkg::Q100_W];
         s1_q100_y_ff    <= s1_prod_y[c2tc_pkg::DIV100_SHIFT +: c2tc_pkg::Q100_W];
         s1_q400_y_ff    <= s1_prod_y4[c2tc_pkg::DIV100_SHIFT +: c2tc_pkg::Q400_W];
         s1_month_ff     <= req_bus.month;
         s1_day_ff       <= req_bus.day;
         s1_tod_ff       <= s1_tod_in;
         s1_ok_ff        <= s1_ok_in;
         s1_day_fits_ff  <= (req_bus.day <= c2tc_pkg::month_length(req_bus.month));
         s1_feb29_ff     <= (req_bus.month == c2tc_pkg::MONTH_FEB)
                         && (req_bus.day == c2tc_pkg::DAY_W'(c2tc_pkg::LEAP_DAY));

         s2_days_year_ff <= s2_days_year_in[c2tc_pkg::DAYS_W-1:0];
         s2_doff_ff      <= s2_doff_in;
         s2_tod_ff       <= s1_tod_ff;
         s2_ok_ff        <= s2_ok_in;

         s3_days_ff      <= s2_days_year_ff + c2tc_pkg::DAYS_W'(s2_doff_ff);
         s3_tod_ff       <= s2_tod_ff;
         s3_ok_ff        <= s2_ok_ff;

         s4_ms_ff        <= s4_ms_in;
         s4_ok_ff        <= s3_ok_ff;

         s5_lo_ff <= (c2tc_pkg::MS_LO_W+c2tc_pkg::TICKS_W)'(s4_ms_ff[c2tc_pkg::MS_LO_W-1:0])
                   * (c2tc_pkg::MS_LO_W+c2tc_pkg::TICKS_W)'(c2tc_pkg::TICKS_PER_MS);
         s5_hi_ff <= (c2tc_pkg::MS_HI_W+c2tc_pkg::TICKS_W)'(s4_ms_ff[c2tc_pkg::MS_W-1:c2tc_pkg::MS_LO_W])
                   * (c2tc_pkg::MS_HI_W+c2tc_pkg::TICKS_W)'(c2tc_pkg::TICKS_PER_MS);
         s5_ok_ff <= s4_ok_ff;

         out_ticks_ff <= out_ticks_in;
         out_ok_ff    <= s5_ok_ff;
      end
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.tick_count  = out_ticks_ff;
   assign rsp_bus.input_valid = out_ok_ff;

   // ---------------- assertions ----------------
   // a rejected timestamp never carries a count
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.input_valid |-> rsp_bus.tick_count == '0)
      else $error("invalid timestamp returned a nonzero tick count");

   // a taken request lands in the first stage
   a_req_enters: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> s1_valid_ff)
      else $error("accepted request missing from stage 1");

   // a held response freezes the valid bits of stages 1 to 5
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable({s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff}))
      else $error("pipeline moved during a stall");

   // out of range month can never pass the checks
   a_month_check: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && (s1_month_ff == '0 || s1_month_ff > c2tc_pkg::MONTH_DEC) |-> !s2_ok_in)
      else $error("bad month passed the range check");

endmodule
